@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the PPM decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("invariant violated");

// Implication checked in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

@@ src/ppmfd_pkg.sv @@
// Package with types, codes and constants of the PPM decoder.
package ppmfd_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 8;
  localparam int unsigned MAX_TICK_CH       = 8;
  localparam int unsigned OUT_DEPTH         = 4;
  localparam int unsigned OUT_CNT_W         = $clog2(OUT_DEPTH + 1);
  localparam int unsigned OUT_PTR_W         = $clog2(OUT_DEPTH);

  localparam logic [15:0] SYNC_GAP_RST = 16'd3000;
  localparam logic [15:0] ALPHA_RST    = 16'd1311;
  localparam logic [7:0]  MASK_RST     = 8'd63;

  typedef enum logic [1:0] {
    CFG_SYNC_GAP     = 2'd0,
    CFG_FILTER_ALPHA = 2'd1,
    CFG_FILTER_MASK  = 2'd2
  } cfg_idx_e;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] pulse_value;
    logic        is_filtered;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

@@ src/ppmfd_mem.sv @@
// Channel store: raw and smoothed value memories with registered reads.
module ppmfd_mem import ppmfd_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int unsigned AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   raw_rdata_o,
  output logic [15:0]   sm_rdata_o,
  input  logic          raw_we_i,
  input  logic [AW-1:0] raw_waddr_i,
  input  logic [15:0]   raw_wdata_i,
  input  logic          sm_we_i,
  input  logic [AW-1:0] sm_waddr_i,
  input  logic [15:0]   sm_wdata_i
);

  logic [15:0]              raw_mem_q [CHANNEL_COUNT];
  logic [15:0]              sm_mem_q  [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] raw_vld_q;
  logic [CHANNEL_COUNT-1:0] sm_vld_q;
  logic [15:0]              raw_rd_q;
  logic [15:0]              sm_rd_q;
  logic                     raw_ok_q;
  logic                     sm_ok_q;

  always_ff @(posedge clk_i) begin
    if (raw_we_i) begin
      raw_mem_q[raw_waddr_i] <= raw_wdata_i;
    end
    if (sm_we_i) begin
      sm_mem_q[sm_waddr_i] <= sm_wdata_i;
    end
    if (rd_en_i) begin
      raw_rd_q <= raw_mem_q[rd_addr_i];
      sm_rd_q  <= sm_mem_q[rd_addr_i];
    end
  end

  // Entries not yet written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_vld_q <= '0;
      sm_vld_q  <= '0;
      raw_ok_q  <= 1'b0;
      sm_ok_q   <= 1'b0;
    end else begin
      if (raw_we_i) begin
        raw_vld_q[raw_waddr_i] <= 1'b1;
      end
      if (sm_we_i) begin
        sm_vld_q[sm_waddr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        raw_ok_q <= raw_vld_q[rd_addr_i];
        sm_ok_q  <= sm_vld_q[rd_addr_i];
      end
    end
  end

  assign raw_rdata_o = raw_ok_q ? raw_rd_q : 16'd0;
  assign sm_rdata_o  = sm_ok_q ? sm_rd_q : 16'd0;

endmodule

@@ src/ppmfd_filter.sv @@
// Low-pass update: multiply stage, then rounding toward zero and accumulate; unsmoothed channels pass raw.
module ppmfd_filter import ppmfd_pkg::*; #(
  parameter int unsigned AW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stage_ctl_t    in_ctl_i,
  input  logic [AW-1:0] in_ch_i,
  input  logic [15:0]   raw_i,
  input  logic [15:0]   prev_i,
  input  logic [15:0]   alpha_i,
  input  logic          smooth_en_i,
  output logic          wb_valid_o,
  output logic [AW-1:0] wb_addr_o,
  output res_t          wb_res_o
);

  logic signed [16:0] diff;
  logic signed [33:0] prod_d;
  logic signed [33:0] prod_q;
  logic signed [33:0] prod_adj;
  logic [15:0]        prev_q;
  logic [15:0]        raw_q;
  logic               en_q;
  logic [AW-1:0]      ch_q;
  stage_ctl_t         ctl_q;
  logic [15:0]        new_val;

  always_comb begin
    diff   = $signed({1'b0, raw_i}) - $signed({1'b0, prev_i});
    prod_d = $signed({1'b0, alpha_i}) * diff;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    prev_q <= prev_i;
    raw_q  <= raw_i;
    en_q   <= smooth_en_i;
    ch_q   <= in_ch_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= in_ctl_i;
    end
  end

  // A negative product is biased before the shift so the quotient truncates toward zero.
  always_comb begin
    prod_adj = prod_q[33] ? prod_q + 34'sd65535 : prod_q;
    new_val  = en_q ? (prev_q + prod_adj[31:16]) : raw_q;
  end

  assign wb_valid_o           = ctl_q.valid;
  assign wb_addr_o            = ch_q;
  assign wb_res_o.channel     = 3'(ch_q);
  assign wb_res_o.pulse_value = new_val;
  assign wb_res_o.is_filtered = 1'b1;
  assign wb_res_o.last        = ctl_q.last;

endmodule

@@ src/ppmfd_out_fifo.sv @@
// Result queue between the decoder core and the output channel.
module ppmfd_out_fifo import ppmfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  res_t                 push_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 out_data_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  res_t                 buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign count_o     = cnt_q;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/ppm_frame_decoder_with_smoothing_unit.sv @@
// Top level of the PPM frame decoder with per-channel low-pass smoothing.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): cmd 0 is a rising edge of the
// PPM line with its microsecond time stamp, cmd 1 is a filter tick.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per transfer.
// An edge inside a frame gives one raw result, queued in the cycle of its
// transfer; sync edges and edges past the last channel give none. A tick walks
// channels 0 to min(CHANNEL_COUNT, 8) - 1 through the channel memories, one
// channel a cycle while the queue has room: read, multiply, write back; its
// results enter the queue in channel order.
// A new item is taken once the previous one has left the memory pipeline.
// Results wait in a four-entry queue; when the receiver stalls, the tick walk
// pauses as the queue fills and input is refused until there is room.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once
// and belong to idle periods. Reset restores the register defaults and makes
// every channel value read as zero; no clearing pass is needed.
`include "assert_macros.svh"

module ppm_frame_decoder_with_smoothing_unit import ppmfd_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned AW      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned IW      = $clog2(CHANNEL_COUNT + 1);
  localparam int unsigned TICK_CH = (CHANNEL_COUNT < MAX_TICK_CH) ? CHANNEL_COUNT
                                                                  : MAX_TICK_CH;
  localparam int unsigned SW      = OUT_CNT_W + 1;
  localparam logic [AW-1:0] TICK_LAST = AW'(TICK_CH - 1);
  localparam logic [IW-1:0] CH_FULL   = IW'(CHANNEL_COUNT);

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        cnt_q;
  logic [31:0]          prev_time_q;
  logic [IW-1:0]        idx_q;
  stage_ctl_t           s1_ctl_q;
  logic [AW-1:0]        s1_ch_q;
  logic [15:0]          sync_gap_q;
  logic [15:0]          alpha_q;
  logic [7:0]           mask_q;

  logic [31:0]          interval;
  logic                 is_sync;
  logic                 in_fire;
  logic                 edge_fire;
  logic                 edge_hit;
  logic                 rd_en;
  logic                 credit_ok;
  logic [SW-1:0]        credit_sum;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic [15:0]          raw_rdata;
  logic [15:0]          sm_rdata;
  logic                 wb_valid;
  logic [AW-1:0]        wb_addr;
  res_t                 wb_res;
  res_t                 edge_res;
  res_t                 push_data;
  logic                 push;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_gap_q <= SYNC_GAP_RST;
      alpha_q    <= ALPHA_RST;
      mask_q     <= MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_GAP:     sync_gap_q <= cfg_wdata_i;
        CFG_FILTER_ALPHA: alpha_q    <= cfg_wdata_i;
        CFG_FILTER_MASK:  mask_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Reads already in flight and results queued all hold a queue slot.
  always_comb begin
    credit_sum = SW'(fifo_cnt) + SW'(s1_ctl_q.valid) + SW'(wb_valid);
    credit_ok  = (credit_sum < SW'(OUT_DEPTH));
    in_ready_o = (state_q == ST_IDLE) && !s1_ctl_q.valid && !wb_valid && credit_ok;
    in_fire    = in_valid_i && in_ready_o;
    interval   = in_data_i.timestamp_us - prev_time_q;
    is_sync    = (interval >= {16'd0, sync_gap_q});
    edge_fire  = in_fire && (in_data_i.cmd == CMD_EDGE);
    edge_hit   = edge_fire && !is_sync && (idx_q < CH_FULL);
    rd_en      = (state_q == ST_TICK) && credit_ok;

    edge_res.channel     = 3'(idx_q);
    edge_res.pulse_value = interval[15:0];
    edge_res.is_filtered = 1'b0;
    edge_res.last        = 1'b1;

    push      = edge_hit || wb_valid;
    push_data = wb_valid ? wb_res : edge_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prev_time_q <= '0;
      idx_q       <= '0;
      s1_ctl_q    <= '0;
      s1_ch_q     <= '0;
    end else begin
      if (edge_fire) begin
        prev_time_q <= in_data_i.timestamp_us;
        if (is_sync) begin
          idx_q <= '0;
        end else if (idx_q < CH_FULL) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      s1_ctl_q.valid <= rd_en;
      s1_ctl_q.last  <= (cnt_q == TICK_LAST);
      s1_ch_q        <= cnt_q;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_data_i.cmd == CMD_TICK)) begin
            state_q <= ST_TICK;
            cnt_q   <= '0;
          end
        end
        ST_TICK: begin
          if (credit_ok) begin
            if (cnt_q == TICK_LAST) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  ppmfd_mem #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .AW           (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (cnt_q),
    .raw_rdata_o(raw_rdata),
    .sm_rdata_o (sm_rdata),
    .raw_we_i   (edge_hit),
    .raw_waddr_i(idx_q[AW-1:0]),
    .raw_wdata_i(interval[15:0]),
    .sm_we_i    (wb_valid),
    .sm_waddr_i (wb_addr),
    .sm_wdata_i (wb_res.pulse_value)
  );

  ppmfd_filter #(
    .AW(AW)
  ) u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ctl_i   (s1_ctl_q),
    .in_ch_i    (s1_ch_q),
    .raw_i      (raw_rdata),
    .prev_i     (sm_rdata),
    .alpha_i    (alpha_q),
    .smooth_en_i(mask_q[3'(s1_ch_q)]),
    .wb_valid_o (wb_valid),
    .wb_addr_o  (wb_addr),
    .wb_res_o   (wb_res)
  );

  ppmfd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .count_o    (fifo_cnt)
  );

  `ASSERT_IMPLIES(a_busy_blocks_input, s1_ctl_q.valid || wb_valid, !in_ready_o)
  `ASSERT_ALWAYS(a_queue_credit_bound, credit_sum <= SW'(OUT_DEPTH))
  `ASSERT_IMPLIES(a_tick_last_drains, wb_valid && wb_res.last, state_q == ST_IDLE && !s1_ctl_q.valid)
  `ASSERT_IMPLIES(a_no_push_collision, wb_valid, !edge_hit)

endmodule

@@ tb/ppm_result_checker.sv @@
// Checker that predicts the PPM decoder's results and compares them with its output channel.
module ppm_result_checker import ppmfd_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  res_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam int unsigned TICK_CH =
    (CHANNEL_COUNT < MAX_TICK_CH) ? CHANNEL_COUNT : MAX_TICK_CH;
  localparam int unsigned PRINT_LIMIT = 200;

  logic [15:0] sync_gap_q;
  logic [15:0] alpha_q;
  logic [7:0]  mask_q;
  logic [31:0] last_edge_us;
  int unsigned next_channel;
  logic [15:0] raw_pulse [CHANNEL_COUNT];
  logic [15:0] smoothed_pulse [MAX_TICK_CH];

  res_t awaited_pulses [$];
  int   mismatches;
  int   awaited_n;

  assign mismatches_o = mismatches;
  assign pending_o    = awaited_n;

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("checker: %s", msg);
    mismatches++;
  endtask

  // Exponential low-pass step; the quotient truncates toward zero as in signed division.
  function automatic logic [15:0] low_pass(logic [15:0] raw, logic [15:0] prev,
                                           logic [15:0] alpha);
    longint diff;
    longint step;
    diff = longint'(raw) - longint'(prev);
    step = (longint'(alpha) * diff) / 65536;
    return 16'(longint'(prev) + step);
  endfunction

  task automatic decode_item(in_item_t item);
    logic [31:0] interval;
    res_t        res;
    if (item.cmd == CMD_EDGE) begin
      interval     = item.timestamp_us - last_edge_us;
      last_edge_us = item.timestamp_us;
      if (interval >= {16'd0, sync_gap_q}) begin
        next_channel = 0;
      end else if (next_channel < CHANNEL_COUNT) begin
        raw_pulse[next_channel] = interval[15:0];
        res.channel     = 3'(next_channel);
        res.pulse_value = interval[15:0];
        res.is_filtered = 1'b0;
        res.last        = 1'b1;
        awaited_pulses.push_back(res);
        next_channel++;
      end
    end else begin
      for (int c = 0; c < TICK_CH; c++) begin
        if (mask_q[c]) smoothed_pulse[c] = low_pass(raw_pulse[c], smoothed_pulse[c], alpha_q);
        else smoothed_pulse[c] = raw_pulse[c];
        res.channel     = 3'(c);
        res.pulse_value = smoothed_pulse[c];
        res.is_filtered = 1'b1;
        res.last        = (c == TICK_CH - 1);
        awaited_pulses.push_back(res);
      end
    end
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (awaited_pulses.size() == 0) begin
      report_mismatch($sformatf("result ch %0d value %0d with nothing awaited",
                                got.channel, got.pulse_value));
      return;
    end
    want = awaited_pulses.pop_front();
    if (got.channel !== want.channel)
      report_mismatch($sformatf("channel expected %0d got %0d", want.channel, got.channel));
    if (got.pulse_value !== want.pulse_value)
      report_mismatch($sformatf("pulse_value of ch %0d expected %0d got %0d",
                                want.channel, want.pulse_value, got.pulse_value));
    if (got.is_filtered !== want.is_filtered)
      report_mismatch($sformatf("is_filtered of ch %0d expected %0b got %0b",
                                want.channel, want.is_filtered, got.is_filtered));
    if (got.last !== want.last)
      report_mismatch($sformatf("last of ch %0d expected %0b got %0b",
                                want.channel, want.last, got.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_gap_q   = SYNC_GAP_RST;
      alpha_q      = ALPHA_RST;
      mask_q       = MASK_RST;
      last_edge_us = '0;
      next_channel = 0;
      for (int c = 0; c < CHANNEL_COUNT; c++) raw_pulse[c] = '0;
      for (int c = 0; c < MAX_TICK_CH; c++) smoothed_pulse[c] = '0;
      awaited_pulses.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_GAP:     sync_gap_q = cfg_wdata_i;
          CFG_FILTER_ALPHA: alpha_q    = cfg_wdata_i;
          CFG_FILTER_MASK:  mask_q     = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      // Results are registered in the output queue before they leave, so outputs are matched first.
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) decode_item(in_data_i);
    end
    awaited_n = awaited_pulses.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the PPM decoder testbench: clock, reset, stimulus, receiver and verdict.
module tb_top;
  import ppmfd_pkg::*;

  localparam int unsigned CHANNELS     = CHANNEL_COUNT_DEF;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam int          TICK_TAIL    = 16;
  localparam int          QUIET_LIMIT  = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  res_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int          mismatches;
  int          pending;

  logic [31:0] now_us;
  logic [15:0] cur_gap;
  bit          calm;
  int          items_sent;

  ppm_frame_decoder_with_smoothing_unit #(
    .CHANNEL_COUNT(CHANNELS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ppm_result_checker #(
    .CHANNEL_COUNT(CHANNELS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Ends the run when neither channel has moved a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  task automatic send_item(logic cmd, logic [31:0] stamp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, timestamp_us: stamp};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic edge_after(logic [31:0] delta);
    now_us = now_us + delta;
    send_item(CMD_EDGE, now_us);
  endtask

  task automatic edge_at(logic [31:0] stamp);
    now_us = stamp;
    send_item(CMD_EDGE, now_us);
  endtask

  task automatic filter_tick();
    send_item(CMD_TICK, $urandom());
  endtask

  // The tail gives a stray extra result time to show up before the settings change.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TICK_TAIL) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [15:0] gap, logic [15:0] alpha, logic [7:0] mask);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SYNC_GAP;
    cfg_wdata <= gap;
    @(posedge clk_i);
    cfg_idx   <= CFG_FILTER_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk_i);
    cfg_idx   <= CFG_FILTER_MASK;
    cfg_wdata <= {8'($urandom()), mask};
    @(posedge clk_i);
    // No register sits behind this index, so the write must leave all settings alone.
    cfg_idx   <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom());
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_gap = gap;
  endtask

  function automatic logic [31:0] channel_interval();
    if (cur_gap == 0) return 32'($urandom_range(0, 3000));
    if (cur_gap > 2100 && $urandom_range(0, 2) != 0) return 32'($urandom_range(900, 2100));
    return 32'($urandom_range(0, cur_gap - 1));
  endfunction

  // Mostly whole frames with random pulse widths, mixed with ticks and stray edges.
  task automatic run_traffic(int target);
    int first;
    int pick;
    int pulses;
    first = items_sent;
    while (items_sent - first < target) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        edge_after(32'(cur_gap) + $urandom_range(0, 4000));
        pulses = $urandom_range(1, CHANNELS + 1);
        for (int k = 0; k < pulses; k++) edge_after(channel_interval());
        if ($urandom_range(0, 1)) filter_tick();
      end else if (pick < 9) begin
        if ($urandom_range(0, 1)) edge_at($urandom());
        else if ($urandom_range(0, 1)) edge_after($urandom_range(0, 70000));
        else send_item(CMD_TICK, $urandom());
      end else begin
        filter_tick();
      end
    end
  endtask

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    now_us     = '0;
    cur_gap    = SYNC_GAP_RST;
    calm       = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a tick on empty channels, an interval equal to the sync gap,
    // a full frame including zero and one microsecond pulses, and one pulse too many.
    filter_tick();
    edge_at(32'd3000);
    edge_after(32'd2999);
    edge_after(32'd0);
    edge_after(32'd1);
    edge_after(32'd1000);
    edge_after(32'd1500);
    edge_after(32'd2000);
    edge_after(32'd2500);
    edge_after(32'd1200);
    edge_after(32'd1800);
    filter_tick();
    // The time stamp wraps past its top value between the edges below.
    edge_at(32'hFFFF_FFFF);
    edge_at(32'h0000_01FF);
    edge_after(32'd2998);
    filter_tick();
    edge_after(32'd4000);
    edge_after(32'd3001);
    edge_after(32'd1500);
    calm = 1'b1;
    filter_tick();
    filter_tick();
    wait_idle();

    apply_config(16'd0, 16'd0, 8'h00);
    run_traffic(10);
    wait_idle();
    apply_config(16'hFFFF, 16'hFFFF, 8'hFF);
    run_traffic(20);
    wait_idle();
    apply_config(16'hFFFF, 16'd1, 8'hA5);
    run_traffic(15);
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      apply_config(16'($urandom_range(1500, 4000)), 16'($urandom()), 8'($urandom()));
      run_traffic(15);
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
